>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the byte minority-position coder. Empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is active
`define BMPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bmpc assertion failed");

// Next-cycle implication, disabled while reset is active
`define BMPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bmpc assertion failed");

`else

`define BMPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define BMPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> sv/bmpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpc_pkg
// Shared widths, constants and types of the byte minority-position coder.
// ----------------------------------------------------------------------------
package bmpc_pkg;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int CODE_W = 19;
  localparam int LEN_W  = 5;
  localparam int CAP_W  = 24;

  // Symbol string: 8 bits plus one end marker
  localparam int SYM_W  = 2;
  localparam int SYMS   = 9;
  localparam int ROT_W  = SYM_W * SYMS;
  localparam int RANK_W = 4;
  localparam int POS_W  = 3;

  localparam logic [SYM_W-1:0] SYM_ZERO   = 2'd0;
  localparam logic [SYM_W-1:0] SYM_ONE    = 2'd1;
  localparam logic [SYM_W-1:0] SYM_MARKER = 2'd2;

  // Codeword length bounds: header plus three bits per minority symbol
  localparam logic [LEN_W-1:0] LEN_MIN = 5'd7;
  localparam logic [LEN_W-1:0] LEN_MAX = 5'd19;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef logic [SYM_W-1:0] sym_t;

  // One classified item waiting for the capacity stage
  typedef struct packed {
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_len;
  } code_entry_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic        valid;
    code_entry_t entry;
  } queue_head_t;

endpackage

>>> sv/bmpc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpc channel interfaces
// Valid/ready channels for message bytes, codewords and the capacity write.
// ----------------------------------------------------------------------------
interface bmpc_in_if;
  logic                          valid;
  logic                          ready;
  logic [bmpc_pkg::BYTE_W-1:0]   message_byte;

  modport source (output valid, output message_byte, input ready);
  modport sink   (input valid, input message_byte, output ready);
endinterface

interface bmpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [bmpc_pkg::CODE_W-1:0]   code_bits;
  logic [bmpc_pkg::LEN_W-1:0]    code_len;
  logic                          emitted;
  logic [bmpc_pkg::CAP_W-1:0]    remaining;

  modport source (output valid, output code_bits, output code_len, output emitted,
                  output remaining, input ready);
  modport sink   (input valid, input code_bits, input code_len, input emitted,
                  input remaining, output ready);
endinterface

interface bmpc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bmpc_pkg::CAP_W-1:0]    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/bmpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpc_front
// Accepts message bytes, takes the BWT of bits plus marker and packs the code.
// ----------------------------------------------------------------------------
module bmpc_front (
  bmpc_in_if.sink                  in_ch,
  input  logic                     queue_full,
  output logic                     push,
  output bmpc_pkg::code_entry_t    push_entry
);
  import bmpc_pkg::*;

  sym_t               syms   [SYMS];
  logic [ROT_W-1:0]   rot    [SYMS];
  logic [RANK_W-1:0]  rank   [SYMS];
  sym_t               bwt    [SYMS];
  logic [RANK_W-1:0]  ones_cnt;
  logic [RANK_W-1:0]  zeros_cnt;
  logic [RANK_W-1:0]  marker_pos;
  logic [RANK_W-1:0]  min_cnt;
  logic               min_val;
  logic [CODE_W-1:0]  code;
  logic [POS_W-1:0]   pos;

  // Handshake: take a byte whenever the queue has room
  assign in_ch.ready = !queue_full;
  assign push        = in_ch.valid && in_ch.ready;

  // Symbol string, MSB first, marker last
  always_comb begin
    for (int i = 0; i < SYMS - 1; i++) begin
      syms[i] = {1'b0, in_ch.message_byte[BYTE_W-1-i]};
    end
    syms[SYMS-1] = SYM_MARKER;
  end

  // Each rotation as one key; first symbol in the top bits
  always_comb begin
    for (int i = 0; i < SYMS; i++) begin
      for (int k = 0; k < SYMS; k++) begin
        rot[i][ROT_W-1-SYM_W*k -: SYM_W] = syms[(i + k) % SYMS];
      end
    end
  end

  // Rank of each rotation: number of rotations that sort below it
  always_comb begin
    for (int i = 0; i < SYMS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < SYMS; j++) begin
        if (j != i && rot[j] < rot[i]) begin
          rank[i] = rank[i] + RANK_W'(1);
        end
      end
    end
  end

  // Transform: last symbol of each sorted rotation
  always_comb begin
    for (int r = 0; r < SYMS; r++) begin
      bwt[r] = SYM_ZERO;
      for (int i = 0; i < SYMS; i++) begin
        if (rank[i] == RANK_W'(r)) begin
          bwt[r] = syms[(i + SYMS - 1) % SYMS];
        end
      end
    end
  end

  // Symbol counts and marker position
  always_comb begin
    ones_cnt   = '0;
    zeros_cnt  = '0;
    marker_pos = '0;
    for (int i = 0; i < SYMS; i++) begin
      if (bwt[i] == SYM_ONE) begin
        ones_cnt = ones_cnt + RANK_W'(1);
      end else if (bwt[i] == SYM_ZERO) begin
        zeros_cnt = zeros_cnt + RANK_W'(1);
      end else begin
        marker_pos = RANK_W'(i);
      end
    end
  end

  // Minority value, zero on a tie
  assign min_val = (ones_cnt < zeros_cnt);
  assign min_cnt = min_val ? ones_cnt : zeros_cnt;

  // Codeword packing: header, then positions with the marker removed
  always_comb begin
    code = CODE_W'({min_val, min_cnt[POS_W-1:0], marker_pos[POS_W-1:0]});
    pos  = '0;
    for (int i = 0; i < SYMS; i++) begin
      if (bwt[i] == {1'b0, min_val}) begin
        pos  = (RANK_W'(i) < marker_pos) ? POS_W'(i) : POS_W'(i - 1);
        code = {code[CODE_W-POS_W-1:0], pos};
      end
    end
  end

  assign push_entry.code_bits = code;
  assign push_entry.code_len  = LEN_MIN + LEN_W'(min_cnt) + LEN_W'({min_cnt, 1'b0});

endmodule

>>> sv/bmpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpc_queue
// Short FIFO of classified items between front and back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmpc_queue #(
  parameter int Depth = bmpc_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  bmpc_pkg::code_entry_t    push_entry,
  output logic                     full,
  input  logic                     pop,
  output bmpc_pkg::queue_head_t    head
);
  import bmpc_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  code_entry_t       slots_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r;
  logic [PtrW-1:0]   rd_ptr_r;
  logic [CntW-1:0]   count_r;
  logic [CntW-1:0]   count_nxt;
  logic              do_pop;

  assign full       = (count_r == CntW'(Depth));
  assign head.valid = (count_r != '0);
  assign head.entry = slots_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  // Occupancy update
  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  `BMPC_ASSERT_IMPL(a_no_push_when_full, clk, rst_n, full, !push)
  `BMPC_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CntW'(Depth))

endmodule

>>> sv/bmpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpc_back
// Charges each codeword against the capacity budget and holds the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmpc_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bmpc_pkg::queue_head_t    head,
  output logic                     pop,
  bmpc_cfg_if.sink                 cfg_ch,
  bmpc_out_if.source               out_ch
);
  import bmpc_pkg::*;

  logic [CAP_W-1:0]   remaining_r;
  logic               halted_r;
  logic               out_valid_r;
  logic [CODE_W-1:0]  code_bits_r;
  logic [LEN_W-1:0]   code_len_r;
  logic               emitted_r;
  logic [CAP_W-1:0]   remaining_out_r;
  logic               cfg_fire;
  logic               fits;
  logic [CAP_W-1:0]   remaining_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  // Take the next item when the output register is free or being drained
  assign pop = head.valid && (!out_valid_r || out_ch.ready);

  // Budget check
  assign fits          = !halted_r && (CAP_W'(head.entry.code_len) <= remaining_r);
  assign remaining_nxt = fits ? remaining_r - CAP_W'(head.entry.code_len) : remaining_r;

  // Budget state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        remaining_r <= cfg_ch.data;
        halted_r    <= 1'b0;
      end else if (pop && !halted_r) begin
        remaining_r <= remaining_nxt;
        halted_r    <= !fits;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      code_bits_r     <= head.entry.code_bits;
      code_len_r      <= head.entry.code_len;
      emitted_r       <= fits;
      remaining_out_r <= remaining_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.code_bits = code_bits_r;
  assign out_ch.code_len  = code_len_r;
  assign out_ch.emitted   = emitted_r;
  assign out_ch.remaining = remaining_out_r;

  `BMPC_ASSERT_IMPL(a_len_range, clk, rst_n, out_valid_r, (code_len_r >= LEN_MIN) && (code_len_r <= LEN_MAX))
  `BMPC_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halted_r && !cfg_fire, halted_r)
  `BMPC_ASSERT_NEXT(a_halt_freezes_budget, clk, rst_n, halted_r && !cfg_fire, $stable(remaining_r))

endmodule

>>> sv/bwt_byte_minority_position_coder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_byte_minority_position_coder_unit
// Byte minority-position coder with a capacity budget.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   takes one message byte per item (valid/ready).
//   out_ch  returns one result per byte: codeword (right-aligned), its length
//           of 7 to 19 bits, an emitted flag and the budget left afterwards.
//   cfg_ch  writes the capacity in bits; this reloads the budget and clears
//           the halt. Write it only while no item is in flight.
// Timing:
//   The front end ranks the 9 rotations and packs the codeword in the accept
//   cycle; the item then sits in a queue (2 entries by default) and the back
//   end charges it against the budget into the output register. Throughput
//   is 1 item per cycle while out_ch.ready stays high, bounded by the
//   single budget subtract-and-compare in the back end.
// Reset (rst_n low, synchronous): budget 0, halt cleared, queue and output
//   emptied. A stalled receiver holds the result; the queue keeps taking
//   bytes until it fills, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module bwt_byte_minority_position_coder_unit #(
  parameter int QueueDepth = bmpc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  bmpc_in_if.sink       in_ch,
  bmpc_cfg_if.sink      cfg_ch,
  bmpc_out_if.source    out_ch
);
  import bmpc_pkg::*;

  logic          push;
  code_entry_t   push_entry;
  logic          queue_full;
  logic          pop;
  queue_head_t   head;

  bmpc_front u_front (
    .in_ch      (in_ch),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  bmpc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head       (head)
  );

  bmpc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

endmodule

>>> tb/bmpc_coder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpc_coder_checker
// Watches the byte, capacity and codeword channels of the minority-position
// coder. It encodes every accepted byte on its own, charges the codeword
// against its own copy of the budget and compares each returned item field
// by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bmpc_coder_checker (
  input  logic clk,
  input  logic rst_n,
  bmpc_in_if   in_mon,
  bmpc_cfg_if  cfg_mon,
  bmpc_out_if  out_mon,
  output int   mismatch_count,
  output int   pending_count,
  output int   emitted_count,
  output int   withheld_count
);
  import bmpc_pkg::*;

  // One predicted result item
  typedef struct {
    code_entry_t        word;
    logic               emitted;
    logic [CAP_W-1:0]   remaining;
  } coded_result_t;

  coded_result_t      pending_codewords[$];
  logic [CAP_W-1:0]   budget_left;
  logic               budget_halted;

  // True when the rotation starting at a sorts below the one starting at b
  function automatic bit rotation_precedes(input sym_t str[SYMS], input int a, input int b);
    sym_t x;
    sym_t y;
    for (int k = 0; k < SYMS; k++) begin
      x = str[(a + k) % SYMS];
      y = str[(b + k) % SYMS];
      if (x != y) return x < y;
    end
    return 1'b0;
  endfunction

  // Byte -> BWT of its 9 symbols -> minority-position codeword
  function automatic code_entry_t encode_byte(input logic [BYTE_W-1:0] b);
    sym_t              str[SYMS];
    sym_t              last_col[SYMS];
    sym_t              minority_sym;
    int                rank;
    int                zeros;
    int                ones;
    int                marker_at;
    int                n_minority;
    int                slot;
    logic              minority;
    logic [CODE_W-1:0] word;
    code_entry_t       entry;
    for (int i = 0; i < 8; i++) str[i] = b[7-i] ? SYM_ONE : SYM_ZERO;
    str[8] = SYM_MARKER;
    // every rotation is distinct, so ranks form a permutation
    for (int i = 0; i < SYMS; i++) begin
      rank = 0;
      for (int j = 0; j < SYMS; j++)
        if (j != i && rotation_precedes(str, j, i)) rank++;
      last_col[rank] = str[(i + SYMS - 1) % SYMS];
    end
    zeros = 0;
    ones = 0;
    marker_at = 0;
    for (int i = 0; i < SYMS; i++) begin
      if (last_col[i] == SYM_ONE) ones++;
      else if (last_col[i] == SYM_ZERO) zeros++;
      else marker_at = i;
    end
    // tie goes to zero
    minority     = (ones >= zeros) ? 1'b0 : 1'b1;
    n_minority   = minority ? ones : zeros;
    minority_sym = minority ? SYM_ONE : SYM_ZERO;
    word = CODE_W'(minority);
    word = (word << 3) | CODE_W'(n_minority[2:0]);
    word = (word << 3) | CODE_W'(marker_at[2:0]);
    for (int i = 0; i < SYMS; i++) begin
      if (last_col[i] == minority_sym) begin
        slot = (i < marker_at) ? i : i - 1;
        word = (word << 3) | CODE_W'(slot[2:0]);
      end
    end
    entry.code_bits = word;
    entry.code_len  = LEN_W'(7 + 3 * n_minority);
    return entry;
  endfunction

  // One line per mismatch, and count it
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatch_count++;
  endtask

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    emitted_count  = 0;
    withheld_count = 0;
    budget_left    = '0;
    budget_halted  = 1'b0;
  end

  always @(posedge clk) begin
    coded_result_t predicted;
    coded_result_t oldest;
    if (!rst_n) begin
      budget_left   = '0;
      budget_halted = 1'b0;
      pending_codewords.delete();
    end else begin
      // Returned item: compare against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (pending_codewords.size() == 0) begin
          report_mismatch("result item with nothing outstanding", 32'd0,
                          32'(out_mon.code_bits));
        end else begin
          oldest = pending_codewords.pop_front();
          if (out_mon.code_bits !== oldest.word.code_bits)
            report_mismatch("code_bits", 32'(oldest.word.code_bits), 32'(out_mon.code_bits));
          if (out_mon.code_len !== oldest.word.code_len)
            report_mismatch("code_len", 32'(oldest.word.code_len), 32'(out_mon.code_len));
          if (out_mon.emitted !== oldest.emitted)
            report_mismatch("emitted", 32'(oldest.emitted), 32'(out_mon.emitted));
          if (out_mon.remaining !== oldest.remaining)
            report_mismatch("remaining", 32'(oldest.remaining), 32'(out_mon.remaining));
          if (oldest.emitted) emitted_count++;
          else withheld_count++;
        end
      end
      // Capacity write reloads the budget and lifts the halt
      if (cfg_mon.valid && cfg_mon.ready) begin
        budget_left   = cfg_mon.data;
        budget_halted = 1'b0;
      end
      // Accepted byte: encode and charge the budget
      if (in_mon.valid && in_mon.ready) begin
        predicted.word    = encode_byte(in_mon.message_byte);
        predicted.emitted = 1'b0;
        if (!budget_halted) begin
          if (CAP_W'(predicted.word.code_len) <= budget_left) begin
            budget_left       = budget_left - CAP_W'(predicted.word.code_len);
            predicted.emitted = 1'b1;
          end else begin
            budget_halted = 1'b1;
          end
        end
        predicted.remaining = budget_left;
        pending_codewords = {pending_codewords, predicted};
      end
      pending_count = pending_codewords.size();
    end
  end

endmodule

>>> tb/tb_bwt_byte_minority_position_coder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bwt_byte_minority_position_coder_unit
// Drives message bytes and capacity writes into the coder: a short directed
// run (reset budget, exact fit, overflow, halt, corner bytes) followed by
// random phases under a range of capacities. The sender runs in bursts, the
// receiver stalls on its own pattern with occasional long hold-offs. The
// checker does all prediction; this module only stimulates and decides.
// ----------------------------------------------------------------------------
module tb_bwt_byte_minority_position_coder_unit;
  import bmpc_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 90;
  localparam int CORNER_COUNT  = 16;
  // all-zero, all-one, single bits, alternating, ties, symmetric patterns
  localparam logic [CORNER_COUNT*8-1:0] CORNER_BYTES =
    {8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA,
     8'h0F, 8'hF0, 8'h3C, 8'hC3, 8'h96, 8'h69, 8'h81, 8'h18};

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count;
  int   bytes_sent;
  int   capacity_writes;
  int   mismatch_count;
  int   pending_count;
  int   emitted_count;
  int   withheld_count;

  bmpc_in_if  in_if ();
  bmpc_out_if out_if ();
  bmpc_cfg_if cfg_if ();

  bwt_byte_minority_position_coder_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .cfg_ch (cfg_if),
    .out_ch (out_if)
  );

  bmpc_coder_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_if),
    .cfg_mon        (cfg_if),
    .out_mon        (out_if),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .emitted_count  (emitted_count),
    .withheld_count (withheld_count)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one byte and hold it until accepted
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    in_if.valid        <= 1'b1;
    in_if.message_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Random bytes in bursts separated by random gaps
  task automatic send_bursts(input int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) push_byte(BYTE_W'($urandom_range(0, 255)));
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid <= 1'b0;
  endtask

  // Capacity write; only called with nothing in flight
  task automatic write_capacity(input logic [CAP_W-1:0] bits);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= bits;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    capacity_writes++;
  endtask

  // Wait until every predicted item has come back
  task automatic drain;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Receiver: free-running, stall-heavy and long hold-off segments
  initial begin
    int seg_no;
    int duty;
    out_if.ready <= 1'b0;
    seg_no = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (seg_no % 5 == 2) begin
        // long hold-off: block fills and must stall its input
        out_if.ready <= 1'b0;
        repeat ($urandom_range(40, 100)) @(posedge clk);
      end else begin
        duty = (seg_no % 5 == 0) ? 0 : $urandom_range(10, 80);
        repeat ($urandom_range(20, 150)) begin
          out_if.ready <= ($urandom_range(0, 99) >= duty);
          @(posedge clk);
        end
      end
      seg_no++;
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d items outstanding",
             cycle_count, pending_count);
    $display("Mismatches found");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    logic [CAP_W-1:0] capacity;
    bytes_sent      = 0;
    capacity_writes = 0;
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.message_byte <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.data        <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset budget is zero: first byte overflows, next is already halted
    push_byte(8'hA5);
    push_byte(8'h00);
    in_if.valid <= 1'b0;
    drain();

    // Exact fit leaves zero, then overflow, then halted
    write_capacity(CAP_W'(7));
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h00);
    in_if.valid <= 1'b0;
    drain();

    // Corner bytes with the largest budget
    write_capacity({CAP_W{1'b1}});
    for (int i = CORNER_COUNT - 1; i >= 0; i--) push_byte(CORNER_BYTES[i*8 +: 8]);
    in_if.valid <= 1'b0;
    drain();

    // Random phases over small, full-range random, all-ones and very small budgets
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: capacity = (ph == 0) ? '0 : CAP_W'($urandom_range(0, 2000));
        1: capacity = CAP_W'($urandom());
        2: capacity = {CAP_W{1'b1}};
        default: capacity = CAP_W'($urandom_range(0, 300));
      endcase
      write_capacity(capacity);
      send_bursts(PHASE_ITEMS);
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d bytes across %0d capacity settings", bytes_sent, capacity_writes);
    $display("Codewords emitted: %0d, withheld by budget or halt: %0d",
             emitted_count, withheld_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
